### src/lsbe_pkg.sv
// ----------------------------------------------------------------------------
// lsbe_pkg
// Shared constants for the record embedder: default sizes, register map,
// register reset values, beat kinds and sample limits.
// ----------------------------------------------------------------------------
package lsbe_pkg;

    localparam int RECORD_BYTES_DEF = 200;
    localparam int MAX_CHANNELS_DEF = 4;

    localparam int SAMPLE_W  = 8;
    localparam int CHANNELS  = 4;
    localparam int CC_W      = 3;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [CC_W-1:0] CHANNEL_COUNT_RST = 3'd3;

    // register index, taken from paddr[2]
    localparam logic REG_CHANNEL_COUNT = 1'b0;

    // beat kinds on s_tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 8'd255;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_DEC = 8'd254;

endpackage

### src/lsbe_ram.sv
// ----------------------------------------------------------------------------
// lsbe_ram
// Generic single-port-write, single-port-read RAM with registered read data
// and a read enable.
// ----------------------------------------------------------------------------
module lsbe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/lsb_record_embedder.sv
// ----------------------------------------------------------------------------
// lsb_record_embedder
// Hides a stored byte record in the parity of pixel samples.
// ----------------------------------------------------------------------------
// One beat is accepted every clock cycle, load or pixel alike, unless
// back-pressure on m_tready stalls the pipeline. A pixel beat first does a
// registered read of the record RAM at the current byte position, then its
// adjusted samples are computed into the output register. A load beat writes
// the RAM and gives no result; a pixel right behind it already sees the new
// byte. Per-byte valid bits, cleared by reset, make the record read as all
// zero until written, so no clearing pass is needed after reset.
module lsb_record_embedder
    import lsbe_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // byte_slot, payload_byte, sample_a..sample_d
    input  logic                s_tuser,   // mode

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // marked_a..marked_d, record_complete, zero pad

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int ADDR_W = $clog2(RECORD_BYTES);

    // configuration
    logic [CC_W-1:0] channel_count_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHANNEL_COUNT))
        begin
            channel_count_reg <= pwdata[CC_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CHANNEL_COUNT)
        begin
            prdata = {{(APB_DW-CC_W){1'b0}}, channel_count_reg};
        end
    end

    // input beat fields
    logic                in_mode;
    logic [7:0]          in_slot;
    logic [7:0]          in_byte;
    logic [SAMPLE_W-1:0] in_sample [CHANNELS];

    assign in_mode = s_tuser;
    assign in_slot = s_tdata[7:0];
    assign in_byte = s_tdata[15:8];

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            in_sample[i] = s_tdata[16 + SAMPLE_W*i +: SAMPLE_W];
        end
    end

    // pipeline control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic accept;
    logic load_we;
    logic pixel_acc;

    assign out_en    = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_en;
    assign accept    = s_tvalid && s_tready;
    assign pixel_acc = accept && (in_mode == MODE_PIXEL);
    assign load_we   = accept && (in_mode == MODE_LOAD)
                       && ({1'b0, in_slot} < 9'(RECORD_BYTES));

    // record position and completion flag
    logic [2:0]        bit_pos_reg;
    logic [2:0]        bit_pos_next;
    logic [ADDR_W-1:0] byte_pos_reg;
    logic [ADDR_W-1:0] byte_pos_next;
    logic              complete_reg;
    logic              complete_next;

    always_comb
    begin
        bit_pos_next  = bit_pos_reg + 3'd1;
        byte_pos_next = byte_pos_reg;
        complete_next = complete_reg;
        if (bit_pos_reg == 3'd7)
        begin
            if (byte_pos_reg == ADDR_W'(RECORD_BYTES - 1))
            begin
                byte_pos_next = '0;
                complete_next = 1'b1;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg  <= '0;
            byte_pos_reg <= '0;
            complete_reg <= 1'b0;
        end
        else if (pixel_acc)
        begin
            bit_pos_reg  <= bit_pos_next;
            byte_pos_reg <= byte_pos_next;
            complete_reg <= complete_next;
        end
    end

    // record store: ram plus per-byte valid bits
    logic [RECORD_BYTES-1:0] written_reg;
    logic [7:0]              ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (load_we)
        begin
            written_reg[in_slot[ADDR_W-1:0]] <= 1'b1;
        end
    end

    lsbe_ram #(
        .DATA_W (8),
        .DEPTH  (RECORD_BYTES),
        .ADDR_W (ADDR_W)
    ) u_record_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (in_slot[ADDR_W-1:0]),
        .wdata (in_byte),
        .re    (pixel_acc),
        .raddr (byte_pos_reg),
        .rdata (ram_rdata)
    );

    // stage 1: waiting on ram read
    logic                s1_written_reg;
    logic [2:0]          s1_bit_reg;
    logic                s1_complete_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= pixel_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_acc)
        begin
            s1_written_reg  <= written_reg[byte_pos_reg];
            s1_bit_reg      <= bit_pos_reg;
            s1_complete_reg <= complete_next;
            s1_sample_reg   <= in_sample;
        end
    end

    // parity adjust
    logic                record_bit;
    logic [7:0]          rec_byte;
    logic [SAMPLE_W-1:0] marked [CHANNELS];

    assign rec_byte   = s1_written_reg ? ram_rdata : 8'd0;
    assign record_bit = rec_byte[s1_bit_reg];

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            marked[i] = s1_sample_reg[i];
            if ((i == 0) || ((i < MAX_CHANNELS) && (CC_W'(i) < channel_count_reg)))
            begin
                if (s1_sample_reg[i][0] != record_bit)
                begin
                    if (s1_sample_reg[i] == SAMPLE_MAX)
                    begin
                        marked[i] = SAMPLE_MAX_DEC;
                    end
                    else
                    begin
                        marked[i] = s1_sample_reg[i] + SAMPLE_W'(1);
                    end
                end
            end
        end
    end

    // output register
    logic [39:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            out_data_reg <= {7'd0, s1_complete_reg, marked[3], marked[2], marked[1], marked[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
